### rtl/rrss_pkg.sv
// Shared types, codes and constants of the round-robin sleep scheduler.
package rrss_pkg;

  localparam int SLOTS = 8;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TICKS_W = 16;
  localparam int SLICE_W = 9;
  localparam int TSLICE_W = 8;
  localparam int OUT_IDX_W = 3;

  localparam logic [SLICE_W-1:0] SLICE_MAX = '1;
  localparam logic [TSLICE_W-1:0] TSLICE_RESET = TSLICE_W'(16);

  // Slot status codes.
  localparam logic [1:0] ST_DEAD     = 2'd0;
  localparam logic [1:0] ST_RUNNABLE = 2'd1;
  localparam logic [1:0] ST_RUNNING  = 2'd2;
  localparam logic [1:0] ST_BLOCKED  = 2'd3;

  // Command codes.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SLEEP = 2'd1;
  localparam logic [1:0] CMD_EXIT  = 2'd2;
  localparam logic [1:0] CMD_FORK  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_TICK,
    S_CHECK,
    S_EXPIRE,
    S_SCAN,
    S_COMMIT,
    S_FORK,
    S_RESULT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_TICK,
    OP_EXPIRE,
    OP_SCAN,
    OP_COMMIT,
    OP_FORK
  } op_t;

  typedef struct packed {
    logic expire;
    logic hit;
    logic dead;
    logic last;
  } dp_stat_t;

  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[OUT_IDX_W-1:0];
  endfunction

endpackage

### rtl/rrss_ctrl.sv
// Sequencing state machine of the scheduler: steps the datapath through one request.
module rrss_ctrl
  import rrss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] command,
  input  dp_stat_t   stat,
  output op_t        op,
  output logic       busy,
  output logic       done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (command)
            CMD_TICK: state_next = S_TICK;
            CMD_FORK: state_next = S_FORK;
            default:  state_next = S_PREP;
          endcase
        end
      end
      S_PREP:   state_next = S_TICK;
      S_TICK:   state_next = S_CHECK;
      S_CHECK:  state_next = stat.expire ? S_EXPIRE : S_RESULT;
      S_EXPIRE: state_next = S_SCAN;
      S_SCAN: begin
        if (stat.hit || stat.last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: state_next = S_RESULT;
      S_FORK: begin
        if (stat.dead || stat.last) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op   = OP_NONE;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          op = OP_LOAD;
        end
      end
      S_PREP:   op = OP_PREP;
      S_TICK:   op = OP_TICK;
      S_CHECK:  op = OP_NONE;
      S_EXPIRE: op = OP_EXPIRE;
      S_SCAN:   op = OP_SCAN;
      S_COMMIT: op = OP_COMMIT;
      S_FORK:   op = OP_FORK;
      S_RESULT: done = 1'b1;
      default:  op = OP_NONE;
    endcase
  end

endmodule

### rtl/rrss_datapath.sv
// Slot tables, running slot, scan pointer and result registers of the scheduler.
module rrss_datapath
  import rrss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  op_t                  op,
  input  logic [1:0]           command,
  input  logic [TICKS_W-1:0]   sleep_ticks,
  input  logic                 cfg_we,
  input  logic [TSLICE_W-1:0]  cfg_wdata,
  output dp_stat_t             stat,
  output logic [OUT_IDX_W-1:0] running_slot,
  output logic                 switched,
  output logic [OUT_IDX_W-1:0] fork_slot,
  output logic                 fork_ok
);

  logic [1:0]          slot_status      [SLOTS];
  logic [1:0]          slot_status_next [SLOTS];
  logic [TICKS_W-1:0]  sleep_left       [SLOTS];
  logic [TICKS_W-1:0]  sleep_left_next  [SLOTS];
  logic [SLICE_W-1:0]  slice_used       [SLOTS];
  logic [SLICE_W-1:0]  slice_used_next  [SLOTS];

  logic [TSLICE_W-1:0] time_slice;
  logic [IDX_W-1:0]    cur, cur_next;
  logic [IDX_W-1:0]    addr, addr_next;
  logic [IDX_W-1:0]    count, count_next;
  logic                found, found_next;
  logic                expire, expire_next;
  logic [1:0]          cmd_q;
  logic [TICKS_W-1:0]  ticks_q;
  logic                sw_q, sw_next;
  logic                fok_q, fok_next;
  logic [IDX_W-1:0]    fslot_q, fslot_next;

  logic [IDX_W-1:0]    addr_inc;
  logic [SLICE_W-1:0]  slice_inc;
  logic [IDX_W-1:0]    tgt;
  logic [TICKS_W-1:0]  dec;

  assign addr_inc  = (addr == IDX_W'(SLOTS - 1)) ? '0 : addr + 1'b1;
  assign slice_inc = (slice_used[addr] == SLICE_MAX) ? SLICE_MAX : slice_used[addr] + 1'b1;
  assign tgt       = found ? addr : '0;

  assign stat.expire = expire;
  assign stat.hit    = (slot_status[addr] == ST_RUNNABLE);
  assign stat.dead   = (slot_status[addr] == ST_DEAD);
  assign stat.last   = (count == IDX_W'(SLOTS - 1));

  always_comb begin
    slot_status_next = slot_status;
    sleep_left_next  = sleep_left;
    slice_used_next  = slice_used;
    cur_next    = cur;
    addr_next   = addr;
    count_next  = count;
    found_next  = found;
    expire_next = expire;
    sw_next     = sw_q;
    fok_next    = fok_q;
    fslot_next  = fslot_q;
    dec         = '0;
    case (op)
      OP_LOAD: begin
        addr_next  = (command == CMD_FORK) ? '0 : cur;
        count_next = '0;
        sw_next    = 1'b0;
        fok_next   = 1'b0;
        fslot_next = '0;
      end
      OP_PREP: begin
        if (cmd_q == CMD_SLEEP) begin
          slot_status_next[addr] = ST_BLOCKED;
          sleep_left_next[addr]  = (ticks_q == '0) ? TICKS_W'(1) : ticks_q;
        end else begin
          slot_status_next[addr] = ST_DEAD;
        end
        slice_used_next[addr] = SLICE_W'(time_slice);
      end
      OP_TICK: begin
        // Every blocked slot counts down at once; the running slot's slice grows.
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_status[i] == ST_BLOCKED) begin
            dec = (sleep_left[i] != '0) ? sleep_left[i] - 1'b1 : '0;
            sleep_left_next[i] = dec;
            if (dec == '0) begin
              slot_status_next[i] = ST_RUNNABLE;
            end
          end
        end
        slice_used_next[addr] = slice_inc;
        expire_next = (slice_inc > SLICE_W'(time_slice));
      end
      OP_EXPIRE: begin
        if (slot_status[addr] == ST_RUNNING) begin
          slot_status_next[addr] = ST_RUNNABLE;
        end
        slice_used_next[addr] = '0;
        addr_next  = addr_inc;
        count_next = '0;
        found_next = 1'b0;
      end
      OP_SCAN: begin
        found_next = stat.hit;
        if (!stat.hit) begin
          addr_next  = addr_inc;
          count_next = count + 1'b1;
        end
      end
      OP_COMMIT: begin
        // With nothing runnable the idle process in slot 0 takes over.
        if (!found) begin
          sleep_left_next[0] = '0;
        end
        cur_next = tgt;
        slot_status_next[tgt] = ST_RUNNING;
        slice_used_next[tgt]  = '0;
        sw_next = 1'b1;
      end
      OP_FORK: begin
        if (stat.dead) begin
          slot_status_next[addr] = ST_RUNNABLE;
          sleep_left_next[addr]  = '0;
          slice_used_next[addr]  = '0;
          fok_next   = 1'b1;
          fslot_next = addr;
        end else begin
          addr_next  = addr_inc;
          count_next = count + 1'b1;
        end
      end
      default: begin
        dec = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_status[i] <= (i == 0) ? ST_RUNNING : ST_DEAD;
        sleep_left[i]  <= '0;
        slice_used[i]  <= '0;
      end
      time_slice <= TSLICE_RESET;
      cur        <= '0;
      addr       <= '0;
      count      <= '0;
      found      <= 1'b0;
      expire     <= 1'b0;
    end else begin
      slot_status <= slot_status_next;
      sleep_left  <= sleep_left_next;
      slice_used  <= slice_used_next;
      if (cfg_we) begin
        time_slice <= cfg_wdata;
      end
      cur    <= cur_next;
      addr   <= addr_next;
      count  <= count_next;
      found  <= found_next;
      expire <= expire_next;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      cmd_q   <= command;
      ticks_q <= sleep_ticks;
    end
    sw_q    <= sw_next;
    fok_q   <= fok_next;
    fslot_q <= fslot_next;
  end

  assign running_slot = to_out_idx(cur);
  assign switched     = sw_q;
  assign fork_slot    = to_out_idx(fslot_q);
  assign fork_ok      = fok_q;

endmodule

### rtl/round_robin_sleep_scheduler_top.sv
// Top level of the round-robin sleep scheduler: controller, datapath and checks.
//
// A request (tick, sleep, exit or fork) is taken when start is high and busy is low;
// its result appears for exactly one cycle with done high and cannot be held off.
// A tick whose slice does not expire passes the tick and check states before done;
// sleep and exit add a prep state, and an expiry adds expire, scan and commit, as the
// next runnable slot is sought one slot per cycle. A fork seeks a dead slot likewise.
// The next request is taken the cycle after done. The user must write time_slice through
// cfg_we and cfg_wdata only while idle; the block itself does not enforce this.
module round_robin_sleep_scheduler_top
  import rrss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           command,
  input  logic [TICKS_W-1:0]   sleep_ticks,
  input  logic                 cfg_we,
  input  logic [TSLICE_W-1:0]  cfg_wdata,
  output logic                 done,
  output logic [OUT_IDX_W-1:0] running_slot,
  output logic                 switched,
  output logic [OUT_IDX_W-1:0] fork_slot,
  output logic                 fork_ok
);

  op_t      op;
  dp_stat_t stat;

  rrss_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .op      (op),
    .busy    (busy),
    .done    (done)
  );

  rrss_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .command      (command),
    .sleep_ticks  (sleep_ticks),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .stat         (stat),
    .running_slot (running_slot),
    .switched     (switched),
    .fork_slot    (fork_slot),
    .fork_ok      (fork_ok)
  );

`ifndef NO_ASSERTIONS
  // An accepted request keeps the block busy and cannot finish in the same cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("request accepted but block not busy");

  // After the result cycle the block is ready again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block still busy after result");

  // A result never reports both a switch and a successful fork.
  a_fork_no_switch: assert property (@(posedge clk) disable iff (rst)
    done |-> !(switched && fork_ok))
    else $error("fork and switch reported together");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for the round-robin sleep scheduler, with its own scheduler model.
`timescale 1ns / 1ps

module tb;
  import rrss_pkg::*;

  typedef struct packed {
    logic [2:0] run_slot;
    logic       sw;
    logic [2:0] child_slot;
    logic       child_ok;
  } sched_result_t;

  typedef struct packed {
    logic [1:0]    cmd;
    logic [15:0]   ticks;
    logic          typed;
    sched_result_t want;
  } dir_row_t;

  localparam sched_result_t NO_RES = '0;
  localparam int DIR_COUNT = 22;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 80;

  // Rows marked as typed carry their result; the others are checked against the model below.
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{CMD_TICK,  16'd0,      1'b1, '{3'd0, 1'b0, 3'd0, 1'b0}},
    '{CMD_FORK,  16'd0,      1'b1, '{3'd0, 1'b0, 3'd1, 1'b1}},
    '{CMD_FORK,  16'hFFFF,   1'b1, '{3'd0, 1'b0, 3'd2, 1'b1}},
    '{CMD_SLEEP, 16'd0,      1'b0, NO_RES},
    '{CMD_EXIT,  16'd0,      1'b0, NO_RES},
    '{CMD_FORK,  16'd0,      1'b0, NO_RES},
    '{CMD_SLEEP, 16'hFFFF,   1'b0, NO_RES},
    '{CMD_SLEEP, 16'hFFFF,   1'b0, NO_RES},
    '{CMD_EXIT,  16'd0,      1'b0, NO_RES},
    '{CMD_FORK,  16'd0,      1'b0, NO_RES},
    '{CMD_FORK,  16'd0,      1'b0, NO_RES},
    '{CMD_FORK,  16'd0,      1'b0, NO_RES},
    '{CMD_FORK,  16'd0,      1'b0, NO_RES},
    '{CMD_FORK,  16'd0,      1'b0, NO_RES},
    '{CMD_FORK,  16'd0,      1'b0, NO_RES},
    '{CMD_FORK,  16'd0,      1'b1, '{3'd0, 1'b0, 3'd0, 1'b0}},
    '{CMD_TICK,  16'hFFFF,   1'b0, NO_RES},
    '{CMD_SLEEP, 16'd1,      1'b0, NO_RES},
    '{CMD_SLEEP, 16'd2,      1'b0, NO_RES},
    '{CMD_TICK,  16'd0,      1'b0, NO_RES},
    '{CMD_EXIT,  16'h5A5A,   1'b0, NO_RES},
    '{CMD_TICK,  16'd0,      1'b0, NO_RES}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [1:0]          command;
  logic [TICKS_W-1:0]  sleep_ticks;
  logic                cfg_we;
  logic [TSLICE_W-1:0] cfg_wdata;
  logic                done;
  logic [2:0]          running_slot;
  logic                switched;
  logic [2:0]          fork_slot;
  logic                fork_ok;

  // Scheduler model state.
  logic [1:0]          slot_st [SLOTS];
  logic [TICKS_W-1:0]  sleep_cnt [SLOTS];
  logic [SLICE_W-1:0]  slice_cnt [SLOTS];
  logic [IDX_W-1:0]    cur_slot;
  logic [TSLICE_W-1:0] slice_limit;

  sched_result_t pending_q [$];
  sched_result_t got_res;
  sched_result_t want_res;
  int            fail_count = 0;
  bit            idle_en;

  round_robin_sleep_scheduler_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .sleep_ticks  (sleep_ticks),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .running_slot (running_slot),
    .switched     (switched),
    .fork_slot    (fork_slot),
    .fork_ok      (fork_ok)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One scheduler tick: wake sleepers, charge the slice, and rotate on expiry.
  function automatic logic sched_tick();
    int   k;
    int   pick;
    logic found;
    for (k = 0; k < SLOTS; k++) begin
      if (slot_st[k] == ST_BLOCKED) begin
        if (sleep_cnt[k] != '0) sleep_cnt[k] = sleep_cnt[k] - 1'b1;
        if (sleep_cnt[k] == '0) slot_st[k] = ST_RUNNABLE;
      end
    end
    if (slice_cnt[cur_slot] != SLICE_MAX) slice_cnt[cur_slot] = slice_cnt[cur_slot] + 1'b1;
    if (slice_cnt[cur_slot] <= {1'b0, slice_limit}) return 1'b0;
    if (slot_st[cur_slot] == ST_RUNNING) slot_st[cur_slot] = ST_RUNNABLE;
    slice_cnt[cur_slot] = '0;
    found = 1'b0;
    pick = 0;
    // The search starts after the current slot and reaches it last.
    for (k = 1; k <= SLOTS; k++) begin
      if (!found && slot_st[(int'(cur_slot) + k) % SLOTS] == ST_RUNNABLE) begin
        pick = (int'(cur_slot) + k) % SLOTS;
        found = 1'b1;
      end
    end
    if (!found) begin
      pick = 0;
      sleep_cnt[0] = '0;
    end
    cur_slot = IDX_W'(pick);
    slot_st[pick] = ST_RUNNING;
    slice_cnt[pick] = '0;
    return 1'b1;
  endfunction

  function automatic sched_result_t sched_step(input logic [1:0] cmd,
                                               input logic [TICKS_W-1:0] ticks);
    sched_result_t r;
    int            k;
    r = '0;
    case (cmd)
      CMD_TICK: r.sw = sched_tick();
      CMD_SLEEP: begin
        slot_st[cur_slot] = ST_BLOCKED;
        sleep_cnt[cur_slot] = (ticks == '0) ? TICKS_W'(1) : ticks;
        slice_cnt[cur_slot] = {1'b0, slice_limit};
        r.sw = sched_tick();
      end
      CMD_EXIT: begin
        slot_st[cur_slot] = ST_DEAD;
        slice_cnt[cur_slot] = {1'b0, slice_limit};
        r.sw = sched_tick();
      end
      default: begin
        for (k = 0; k < SLOTS; k++) begin
          if (!r.child_ok && slot_st[k] == ST_DEAD) begin
            slot_st[k] = ST_RUNNABLE;
            sleep_cnt[k] = '0;
            slice_cnt[k] = '0;
            r.child_slot = 3'(k);
            r.child_ok = 1'b1;
          end
        end
      end
    endcase
    r.run_slot = 3'(cur_slot);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      got_res = '{running_slot, switched, fork_slot, fork_ok};
      if (pending_q.size() == 0) begin
        $display("%0t: result with no request outstanding: expected none, got %h",
                 $time, got_res);
        fail_count++;
      end else begin
        want_res = pending_q.pop_front();
        check_field("running_slot", 8'(want_res.run_slot), 8'(got_res.run_slot));
        check_field("switched", 8'(want_res.sw), 8'(got_res.sw));
        check_field("fork_slot", 8'(want_res.child_slot), 8'(got_res.child_slot));
        check_field("fork_ok", 8'(want_res.child_ok), 8'(got_res.child_ok));
      end
    end
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input logic [1:0] cmd, input logic [TICKS_W-1:0] ticks,
                              input logic typed, input sched_result_t typed_res);
    sched_result_t r;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start       <= 1'b1;
    command     <= cmd;
    sleep_ticks <= ticks;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = sched_step(cmd, ticks);
    pending_q.push_back(typed ? typed_res : r);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_slice(input logic [TSLICE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    slice_limit = value;
  endtask

  initial begin
    int                 p;
    int                 n;
    int                 w;
    logic [1:0]         cmd;
    logic [TICKS_W-1:0] ticks;
    logic [TSLICE_W-1:0] slice_val;
    rst         = 1'b1;
    start       = 1'b0;
    command     = CMD_TICK;
    sleep_ticks = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    idle_en     = 1'b1;
    slice_limit = TSLICE_RESET;
    cur_slot    = '0;
    for (n = 0; n < SLOTS; n++) begin
      slot_st[n]   = ST_DEAD;
      sleep_cnt[n] = '0;
      slice_cnt[n] = '0;
    end
    slot_st[0] = ST_RUNNING;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < DIR_COUNT; n++)
      send_request(DIR_ROWS[n].cmd, DIR_ROWS[n].ticks, DIR_ROWS[n].typed, DIR_ROWS[n].want);

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: slice_val = 8'd0;
        1: slice_val = 8'd255;
        2: slice_val = 8'd1;
        3: slice_val = 8'd3;
        4: slice_val = 8'($urandom_range(2, 40));
        default: slice_val = TSLICE_RESET;
      endcase
      write_slice(slice_val);
      // The final phase runs with the sender at full rate.
      idle_en = (p != PHASES - 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        w = $urandom_range(0, 99);
        if (w < 50) cmd = CMD_TICK;
        else if (w < 70) cmd = CMD_SLEEP;
        else if (w < 82) cmd = CMD_EXIT;
        else cmd = CMD_FORK;
        ticks = 16'($urandom);
        // Sleeps are mostly short, so that blocked slots wake again within the run.
        if (cmd == CMD_SLEEP) begin
          w = $urandom_range(0, 39);
          if (w < 30) ticks = 16'($urandom_range(0, 6));
          else if (w < 38) ticks = 16'($urandom_range(7, 60));
          else if (w == 39) ticks = 16'hFFFF;
        end
        send_request(cmd, ticks, 1'b0, NO_RES);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
